@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W = 16;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

endpackage

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left_entry,
  input  logic            left_ins,
  input  spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t entry,
  output logic            ins
);
  import spq_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [PRIO_W-1:0] prio_r;
  logic [PRIO_W-1:0] prio_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [TAG_W-1:0]  tag_nxt;

  // The new request goes in at or ahead of this cell when the cell is empty
  // or holds a strictly larger priority, which keeps equal priorities in order.
  assign ins = !valid_r || ($signed(cmd.prio) < $signed(prio_r));

  assign entry.valid = valid_r;
  assign entry.prio  = prio_r;
  assign entry.tag   = tag_r;

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (cmd.enq) begin
      if (ins && left_ins) begin
        valid_nxt = left_entry.valid;
        prio_nxt  = left_entry.prio;
        tag_nxt   = left_entry.tag;
      end else if (ins) begin
        valid_nxt = 1'b1;
        prio_nxt  = cmd.prio;
        tag_nxt   = cmd.tag;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_entry.valid;
      prio_nxt  = right_entry.prio;
      tag_nxt   = right_entry.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Sorted priority queue of QUEUE_DEPTH entries, smallest priority served first
// and equal priorities first-in first-out. A request is taken on every cycle in
// which start is high, since busy never rises; its single result appears in the
// next cycle for exactly one cycle, marked by out_valid, and must be captured
// then because the receiver cannot stall the block. The entries sit in a row
// of compare-and-shift cells, each of which decides locally whether to keep its
// entry, take the new one or take a neighbour's, so an enqueue or a dequeue
// updates every cell at once whatever the fill level.
module sorted_priority_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic signed [spq_pkg::PRIO_W-1:0]    in_entry_priority,
  input  logic        [spq_pkg::TAG_W-1:0]     in_entry_tag,
  output logic                                 out_valid,
  output logic        [1:0]                    out_status,
  output logic signed [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic        [spq_pkg::TAG_W-1:0]     out_tag,
  output logic        [spq_pkg::OCC_W-1:0]     out_occupancy
);
  import spq_pkg::*;

  entry_t            cell_entry [QUEUE_DEPTH];
  logic              cell_ins   [QUEUE_DEPTH];
  cmd_t              cmd;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W+OCC_W-1:0] count_wide;
  status_t           status_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [PRIO_W-1:0] out_priority_r;
  logic [PRIO_W-1:0] prio_nxt;
  logic [TAG_W-1:0]  out_tag_r;
  logic [TAG_W-1:0]  tag_nxt;
  logic [OCC_W-1:0]  out_occupancy_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  assign cmd.enq  = accept && (in_kind == KIND_ENQ) && !is_full;
  assign cmd.deq  = accept && (in_kind == KIND_DEQ) && !is_empty;
  assign cmd.prio = in_entry_priority;
  assign cmd.tag  = in_entry_tag;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_i;
    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_i = 1'b0;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_i = cell_ins[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_e),
      .left_ins    (left_i),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .ins         (cell_ins[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_ENQUEUED;
    prio_nxt   = '0;
    tag_nxt    = '0;
    if (in_kind == KIND_ENQ) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_DEQUEUED;
        count_nxt  = count_r - CNT_W'(1);
        prio_nxt   = cell_entry[0].prio;
        tag_nxt    = cell_entry[0].tag;
      end
    end
  end

  assign count_wide = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_priority_r  <= prio_nxt;
      out_tag_r       <= tag_nxt;
      out_occupancy_r <= count_wide[OCC_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_priority_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occupancy_r;

endmodule

@@ bench/sorted_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 550;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic                     kind;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
  } queue_request_t;

  typedef struct {
    status_t                  status;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
    logic [OCC_W-1:0]         occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = KIND_ENQ;
  logic signed [PRIO_W-1:0] in_entry_priority = '0;
  logic [TAG_W-1:0] in_entry_tag = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0] out_tag;
  logic [OCC_W-1:0] out_occupancy;

  queue_request_t pending_requests[$];
  queue_result_t expected_responses[$];

  logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
  logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
  int held_count = 0;

  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  logic steady_stretch = 1'b0;

  sorted_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_entry_priority (in_entry_priority),
    .in_entry_tag      (in_entry_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_priority      (out_priority),
    .out_tag           (out_tag),
    .out_occupancy     (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic serve_request(input logic kind, input logic signed [PRIO_W-1:0] prio,
                               input logic [TAG_W-1:0] tag, output queue_result_t res);
    int pos;
    res.prio = '0;
    res.tag = '0;
    if (kind == KIND_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_prio[pos] = prio;
        held_tag[pos] = tag;
        held_count++;
        res.status = ST_ENQUEUED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.prio = held_prio[0];
        res.tag = held_tag[0];
        for (int i = 1; i < held_count; i++) begin
          held_prio[i-1] = held_prio[i];
          held_tag[i-1] = held_tag[i];
        end
        held_count--;
        res.status = ST_DEQUEUED;
      end
    end
    res.occupancy = held_count[OCC_W-1:0];
  endtask

  task automatic add_request(input logic kind, input logic signed [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag);
    queue_request_t req;
    req.kind = kind;
    req.prio = prio;
    req.tag = tag;
    pending_requests.push_back(req);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    logic signed [PRIO_W-1:0] p;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      p = PRIO_W'($urandom_range(0, 6));
      p = p - 16'sd3;
    end else if (roll < 50) begin
      p = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else begin
      p = PRIO_W'($urandom());
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_priority_queue regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    queue_result_t predicted;
    queue_request_t next_req;
    logic next_start;
    int roll;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start && busy;
      if (start && !busy) begin
        serve_request(in_kind, in_entry_priority, in_entry_tag, predicted);
        expected_responses.push_back(predicted);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          next_start = 1'b1;
          in_kind <= next_req.kind;
          in_entry_priority <= next_req.prio;
          in_entry_tag <= next_req.tag;
          if ($urandom_range(0, 39) == 0) steady_stretch = !steady_stretch;
          roll = $urandom_range(0, 99);
          if (steady_stretch || roll < 60) gap_left = 0;
          else if (roll < 92) gap_left = $urandom_range(1, 3);
          else gap_left = $urandom_range(8, 40);
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d prio %0d tag %0h",
                                  out_status, out_priority, out_tag));
      end else begin
        want = expected_responses.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status expected %s got %0d", want.status.name(),
                                    out_status));
        if (out_priority !== want.prio)
          report_mismatch($sformatf("priority expected %0d got %0d", want.prio, out_priority));
        if (out_tag !== want.tag)
          report_mismatch($sformatf("tag expected %0h got %0h", want.tag, out_tag));
        if (out_occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy expected %0d got %0d", want.occupancy,
                                    out_occupancy));
      end
    end
  end

  initial begin
    int issued;
    int burst_len;
    logic burst_kind;
    logic kind;

    // A request on an empty queue, then a fill with extremes and ties, one refused request
    // on the full queue and a partial drain.
    add_request(KIND_DEQ, 16'sh7FFF, 16'hFFFF);
    add_request(KIND_ENQ, 16'sh0000, 16'h0000);
    add_request(KIND_ENQ, 16'sh7FFF, 16'hFFFF);
    add_request(KIND_ENQ, 16'sh8000, 16'h5555);
    add_request(KIND_ENQ, -16'sd1, 16'hAAAA);
    add_request(KIND_ENQ, 16'sh0000, 16'h0001);
    add_request(KIND_ENQ, 16'sh0000, 16'h0002);
    add_request(KIND_ENQ, 16'sh8000, 16'h0003);
    add_request(KIND_ENQ, 16'sh7FFF, 16'h0004);
    for (int i = 0; i < QUEUE_DEPTH - 8; i++)
      add_request(KIND_ENQ, PRIO_W'(i % 3) - 16'sd1, TAG_W'(16'h0100 + i));
    add_request(KIND_ENQ, 16'sh0005, 16'h1234);
    for (int i = 0; i < 4; i++) add_request(KIND_DEQ, '0, '0);

    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      burst_kind = $urandom_range(0, 1) ? KIND_DEQ : KIND_ENQ;
      burst_len = $urandom_range(1, 24);
      for (int i = 0; i < burst_len && issued < RANDOM_REQUESTS; i++) begin
        kind = ($urandom_range(0, 99) < 85) ? burst_kind : !burst_kind;
        add_request(kind, pick_priority(), TAG_W'($urandom()));
        issued++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || start || expected_responses.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_responses.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_responses.size()));

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
